/* src/sum_of_sines_water_pixel_shader_macros.svh */
// Assertion macros shared by the shader RTL.
`ifndef SUM_OF_SINES_WATER_PIXEL_SHADER_MACROS_SVH
`define SUM_OF_SINES_WATER_PIXEL_SHADER_MACROS_SVH
`ifndef NO_ASSERTIONS
// a implies b in the same cycle
`define SOSW_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("shader assertion failed");
// a implies b after the delay given by n
`define SOSW_ASSERT_DELAY(label, clk, rst, a, n, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
      else $error("shader latency assertion failed");
`else
`define SOSW_ASSERT_IMPLY(label, clk, rst, a, b)
`define SOSW_ASSERT_DELAY(label, clk, rst, a, n, b)
`endif
`endif

/* src/sosw_pkg.sv */
// Types, constants and elaboration-time tables of the water shader.
package sosw_pkg;

   localparam int MAX_SIDE         = 1024;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int WAVE_COUNT       = 6;
   localparam int LANES            = WAVE_COUNT + 1;
   localparam int RIPPLE_LANE      = WAVE_COUNT;
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);

   localparam longint TWO_PI_E9   = 64'sd6283185307;
   localparam longint PI_HALF_Q30 = 64'sd1686629713;

   // Taylor series denominators (2n)*(2n+1) for n = 1..7
   localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                         64'sd110, 64'sd156, 64'sd210};

   typedef struct packed {
      logic [9:0] column;
      logic [9:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0] glyph_code;
      logic [3:0] color_index;
      logic [3:0] color_attribute;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_TIME_VALUE    = 3'd2,
      CSR_WAVE_SCALE    = 3'd3,
      CSR_DRIFT_X       = 3'd4,
      CSR_DRIFT_Y       = 3'd5
   } csr_index_type;

   // wave set: direction (hundredths), frequency (thousandths), speed,
   // amplitude (hundredths), phase (tenths)
   localparam int WAVE_DX    [6] = '{96, -63, 25, -88, 71, -10};
   localparam int WAVE_DY    [6] = '{28, 78, -97, -47, -70, 99};
   localparam int WAVE_FREQ  [6] = '{105, 71, 160, 130, 205, 48};
   localparam int WAVE_SPEED [6] = '{92, 141, 57, 108, 179, 68};
   localparam int WAVE_AMP   [6] = '{62, 43, 25, 30, 17, 32};
   localparam int WAVE_PHASE [6] = '{3, 15, 24, 36, 7, 51};

   localparam logic [3:0] WATER_ATTR [12] =
      '{4'd0, 4'd1, 4'd1, 4'd3, 4'd3, 4'd11, 4'd11, 4'd7, 4'd15, 4'd15, 4'd15, 4'd15};

   typedef logic [14:0] sine_rom_type [0:SINE_TABLE_DEPTH];
   typedef logic signed [21:0] coord_coef_type [LANES];
   typedef logic [23:0] time_coef_type [LANES];
   typedef logic [31:0] phase_coef_type [LANES];

   // value/(2*pi) in Q24 turns, rounded half away from zero
   function automatic longint turns_q24(longint num, longint mul);
      longint n;
      n = num * 64'sd16777216 * mul;
      if (n >= 0)
         return (n + TWO_PI_E9 / 2) / TWO_PI_E9;
      return -((-n + TWO_PI_E9 / 2) / TWO_PI_E9);
   endfunction

   // quarter-wave Q14 sine, endpoint included
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      longint a;
      longint a2;
      longint term;
      longint sum;
      longint v;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         a = (PI_HALF_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
         a2 = (a * a) >>> 30;
         term = a;
         sum = a;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * a2) >>> 30) / TAYLOR_DIV[n - 1];
            sum = (n % 2 == 1) ? sum - term : sum + term;
         end
         if (sum < 0)
            sum = 0;
         v = (sum + 32768) >>> 16;
         rom[k] = (v > 16384) ? 15'd16384 : v[14:0];
      end
      return rom;
   endfunction

   function automatic coord_coef_type build_coef_x();
      coord_coef_type c;
      for (int i = 0; i < LANES; i++)
         c[i] = (i < WAVE_COUNT)
            ? 22'(turns_q24(longint'(WAVE_DX[i] * WAVE_FREQ[i]), 64'sd10000))
            : 22'(turns_q24(64'sd33, 64'sd10000000));
      return c;
   endfunction

   function automatic coord_coef_type build_coef_y();
      coord_coef_type c;
      for (int i = 0; i < LANES; i++)
         c[i] = (i < WAVE_COUNT)
            ? 22'(turns_q24(longint'(WAVE_DY[i] * WAVE_FREQ[i]), 64'sd10000))
            : 22'(turns_q24(-64'sd19, 64'sd10000000));
      return c;
   endfunction

   function automatic time_coef_type build_coef_t();
      time_coef_type c;
      for (int i = 0; i < LANES; i++)
         c[i] = (i < WAVE_COUNT)
            ? 24'(turns_q24(longint'(WAVE_SPEED[i]), 64'sd10000000))
            : 24'(turns_q24(64'sd270, 64'sd10000000));
      return c;
   endfunction

   function automatic phase_coef_type build_coef_p();
      phase_coef_type c;
      for (int i = 0; i < LANES; i++)
         c[i] = (i < WAVE_COUNT)
            ? 32'(turns_q24(longint'(WAVE_PHASE[i]), 64'sd100000000) <<< 8)
            : 32'd0;
      return c;
   endfunction

   localparam sine_rom_type   SINE_ROM = build_sine();
   localparam coord_coef_type COEF_X   = build_coef_x();
   localparam coord_coef_type COEF_Y   = build_coef_y();
   localparam time_coef_type  COEF_T   = build_coef_t();
   localparam phase_coef_type COEF_P   = build_coef_p();

endpackage

/* src/sum_of_sines_water_pixel_shader.sv */
// Top level of the sum-of-sines water shader pipeline.
// One cell word is taken in every clock (busy stays low); its glyph and color reach the
// result ports, marked by rsp_strobe, once the cell has passed all register stages.
// The seven register stages
// are coordinate mapping, phase products, phase sum with sine lookup, wave sum,
// reciprocal divides, gain with level clamp, and index mapping. Results cannot be held
// off, so nothing is buffered. Write the registers only while no cell is in flight.
`include "sum_of_sines_water_pixel_shader_macros.svh"

module sum_of_sines_water_pixel_shader
   import sosw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration
   logic [10:0]        screen_width_ff;
   logic [10:0]        screen_height_ff;
   logic [31:0]        time_value_ff;
   logic [9:0]         wave_scale_ff;
   logic signed [15:0] drift_x_ff;
   logic signed [14:0] drift_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 11'd80;
         screen_height_ff <= 11'd25;
         time_value_ff    <= 32'd0;
         wave_scale_ff    <= 10'd256;
         drift_x_ff       <= 16'sd0;
         drift_y_ff       <= 15'sd0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[10:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[10:0];
            CSR_TIME_VALUE:    time_value_ff    <= csr_data;
            CSR_WAVE_SCALE:    wave_scale_ff    <= csr_data[9:0];
            CSR_DRIFT_X:       drift_x_ff       <= $signed(csr_data[15:0]);
            CSR_DRIFT_Y:       drift_y_ff       <= $signed(csr_data[14:0]);
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // floor(m/5) - offset for an offset-biased nonnegative m
   function automatic logic signed [13:0] floor_div5(logic [15:0] m);
      logic [29:0] p;
      p = {14'd0, m} * 30'd13108;
      return $signed(p[29:16]) - 14'sd820;
   endfunction

   logic [10:0] w_eff;
   logic [10:0] h_eff;
   logic signed [12:0] dx;
   logic signed [12:0] dy;
   logic [15:0] mx;
   logic [15:0] my;
   logic signed [26:0] x_in;
   logic signed [26:0] y_in;

   // stage 1: centered, scaled, drifted coordinates (Q14)
   always_comb begin
      w_eff = (screen_width_ff > 11'(MAX_SIDE)) ? 11'(MAX_SIDE) : screen_width_ff;
      h_eff = (screen_height_ff > 11'(MAX_SIDE)) ? 11'(MAX_SIDE) : screen_height_ff;
      dx = $signed({2'b0, req_item.column, 1'b0}) - $signed({2'b0, w_eff});
      dy = $signed({2'b0, req_item.row, 1'b0}) - $signed({2'b0, h_eff});
      // x: d*63488/5 = 12697*d + floor(3d/5); y: d*98304/5 = 19660*d + floor(4d/5)
      mx = 16'($signed({{3{dx[12]}}, dx}) * 16'sd3 + 16'sd4100);
      my = 16'($signed({{3{dy[12]}}, dy}) * 16'sd4 + 16'sd4100);
      x_in = 27'(dx) * 27'sd12697 + 27'(floor_div5(mx)) + 27'(drift_x_ff) * 27'sd56;
      y_in = 27'(dy) * 27'sd19660 + 27'(floor_div5(my)) + 27'(drift_y_ff) * 27'sd44;
   end

   logic               v1_ff;
   logic signed [26:0] x1_ff;
   logic signed [26:0] y1_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= start && !busy;
      x1_ff <= x_in;
      y1_ff <= y_in;
   end

   // stage 2: phase products per lane
   logic               v2_ff;
   logic [31:0]        px2_ff [LANES];
   logic [31:0]        py2_ff [LANES];
   logic [31:0]        pt2_ff [LANES];
   logic [31:0]        px_in  [LANES];
   logic [31:0]        py_in  [LANES];
   logic [31:0]        pt_in  [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic signed [48:0] prod_x;
         logic signed [48:0] prod_y;
         logic [55:0]        prod_t;
         prod_x = 49'(x1_ff) * 49'(COEF_X[l]);
         prod_y = 49'(y1_ff) * 49'(COEF_Y[l]);
         prod_t = {24'd0, time_value_ff} * {32'd0, COEF_T[l]};
         px_in[l] = prod_x[37:6];
         py_in[l] = prod_y[37:6];
         pt_in[l] = prod_t[39:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else
         v2_ff <= v1_ff;
      px2_ff <= px_in;
      py2_ff <= py_in;
      pt2_ff <= pt_in;
   end

   // stage 3: phase sum, quarter-wave lookup
   logic               v3_ff;
   logic signed [15:0] s3_ff [LANES];
   logic signed [15:0] s_in  [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [31:0] ph;
         logic [10:0] off;
         logic [24:0] idx_wide;
         logic [SINE_IDX_W-1:0] idx;
         logic [14:0] mag;
         ph = px2_ff[l] + py2_ff[l] + pt2_ff[l] + COEF_P[l];
         off = {1'b0, ph[29:20]};
         // mirror the offset in odd quadrants
         if (ph[30])
            off = 11'd1024 - off;
         idx_wide = ({14'd0, off} * 25'(SINE_TABLE_DEPTH)) >> 10;
         if (idx_wide > 25'(SINE_TABLE_DEPTH))
            idx = SINE_IDX_W'(SINE_TABLE_DEPTH);
         else
            idx = idx_wide[SINE_IDX_W-1:0];
         mag = SINE_ROM[idx];
         s_in[l] = ph[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v3_ff <= 1'b0;
      else
         v3_ff <= v2_ff;
      s3_ff <= s_in;
   end

   // stage 4: weighted wave sum, biased ripple numerator
   logic               v4_ff;
   logic signed [23:0] acc4_ff;
   logic [18:0]        rm4_ff;
   logic signed [23:0] acc_in;
   logic signed [19:0] rm_in;

   always_comb begin
      acc_in = 24'sd0;
      for (int i = 0; i < WAVE_COUNT; i++)
         acc_in = acc_in + 24'(s3_ff[i]) * 24'(WAVE_AMP[i]);
      rm_in = 20'(s3_ff[RIPPLE_LANE]) * 20'sd11 + 20'sd180400;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v4_ff <= 1'b0;
      else
         v4_ff <= v3_ff;
      acc4_ff <= acc_in;
      rm4_ff  <= rm_in[18:0];
   end

   // stage 5: divide by 209 and by 200 through reciprocals
   logic               v5_ff;
   logic signed [16:0] ht5_ff;
   logic signed [12:0] rip5_ff;
   logic [22:0]        am;
   logic [46:0]        hq;
   logic [38:0]        rq;

   always_comb begin
      am = 23'(acc4_ff + 24'sd3424256);
      hq = {24'd0, am} * 47'd10275042;
      rq = {20'd0, rm4_ff} * 39'd671089;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v5_ff <= 1'b0;
      else
         v5_ff <= v4_ff;
      ht5_ff  <= $signed({1'b0, hq[46:31]}) - 17'sd16384;
      rip5_ff <= $signed({1'b0, rq[38:27]}) - 13'sd902;
   end

   // stage 6: gain, level clamp
   logic               v6_ff;
   logic [14:0]        lvl6_ff;
   logic signed [12:0] rip6_ff;
   logic signed [27:0] gp;
   logic signed [19:0] lraw;
   logic [14:0]        lvl_in;

   always_comb begin
      gp = 28'(ht5_ff) * $signed({18'd0, wave_scale_ff});
      lraw = 20'((gp >>> 8) + 28'sd16384) >>> 1;
      if (lraw < 0)
         lvl_in = 15'd0;
      else if (lraw > 20'sd16384)
         lvl_in = 15'd16384;
      else
         lvl_in = lraw[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         v6_ff <= 1'b0;
      else
         v6_ff <= v5_ff;
      lvl6_ff <= lvl_in;
      rip6_ff <= rip5_ff;
   end

   // stage 7: glyph and color indices
   logic signed [15:0] gsum;
   logic signed [22:0] gprod;
   logic signed [8:0]  graw;
   logic [6:0]         gi;
   logic [18:0]        cprod;
   logic [3:0]         ci;

   always_comb begin
      gsum = $signed({1'b0, lvl6_ff}) + 16'(rip6_ff);
      gprod = 23'(gsum) * 23'sd94;
      graw = 9'(gprod >>> 14);
      if (graw < 0)
         gi = 7'd0;
      else if (graw > 9'sd94)
         gi = 7'd94;
      else
         gi = graw[6:0];
      cprod = {4'd0, lvl6_ff} * 19'd11;
      ci = (cprod[18:14] > 5'd11) ? 4'd11 : cprod[17:14];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_strobe <= 1'b0;
      else
         rsp_strobe <= v6_ff;
      rsp_item.glyph_code      <= gi + 7'd32;
      rsp_item.color_index     <= ci;
      rsp_item.color_attribute <= WATER_ATTR[ci];
   end

   `SOSW_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 7, rsp_strobe)
   `SOSW_ASSERT_IMPLY(a_color_range, clock, reset, rsp_strobe, rsp_item.color_index <= 4'd11)
   `SOSW_ASSERT_IMPLY(a_glyph_low, clock, reset, rsp_strobe, rsp_item.glyph_code >= 7'd32)
   `SOSW_ASSERT_IMPLY(a_glyph_high, clock, reset, rsp_strobe, rsp_item.glyph_code <= 7'd126)

endmodule
